/* hw/rtl/hbsp_pkg.sv */
// Shared widths, codes, reset values and types for the H-bridge speed-to-PWM core.
package hbsp_pkg;

    localparam int SPEED_W    = 16;
    localparam int DZ_W       = 10;
    localparam int PERIOD_W   = 16;
    localparam int CMP_W      = 16;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int PULSE_MAX_DEF = 1000;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DZ_FWD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DZ_BWD  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 8'd3;

    localparam logic [DZ_W-1:0]     DZ_FWD_RST = 10'd20;
    localparam logic [DZ_W-1:0]     DZ_BWD_RST = 10'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd999;

    typedef struct packed {
        logic             pin_a;
        logic             pin_b;
        logic [DIR_W-1:0] dir;
        logic             sw;
    } hbsp_tag_t;

endpackage

/* hw/rtl/hbsp_scale.sv */
// Compare value pipeline: product by period, reciprocal divide by PULSE_MAX, correction.
module hbsp_scale
    import hbsp_pkg::*;
#(
    parameter int PULSE_MAX = PULSE_MAX_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [$clog2(PULSE_MAX+1)-1:0]       mag,
    input  hbsp_tag_t                            tag,
    input  logic [PERIOD_W-1:0]                  period,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [CMP_W-1:0]                     cmp,
    output hbsp_tag_t                            out_tag
);

    localparam int MAG_W = $clog2(PULSE_MAX + 1);
    localparam int PW    = MAG_W + PERIOD_W;
    localparam int MW    = PW + 1;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << PW) / 64'(PULSE_MAX));

    logic              vp_reg, vp_next;
    logic              ve_reg, ve_next;
    logic              vo_reg, vo_next;
    logic              p_ready, e_ready, o_ready;
    logic [PW-1:0]     prod_reg;
    hbsp_tag_t         ptag_reg;
    logic [PW-1:0]     prod2_reg;
    logic [CMP_W-1:0]  qest_reg;
    hbsp_tag_t         etag_reg;
    logic [CMP_W-1:0]  cmp_reg;
    hbsp_tag_t         otag_reg;

    logic [PW+MW-1:0]  full;
    logic [PW-1:0]     qp;
    logic [PW-1:0]     rem;
    logic              corr;
    logic [CMP_W-1:0]  cmp_next;

    assign o_ready  = !vo_reg || out_ready;
    assign e_ready  = !ve_reg || o_ready;
    assign p_ready  = !vp_reg || e_ready;
    assign in_ready = p_ready;

    assign vp_next = p_ready ? in_valid : vp_reg;
    assign ve_next = e_ready ? vp_reg : ve_reg;
    assign vo_next = o_ready ? ve_reg : vo_reg;

    always_comb
    begin
        full = (PW+MW)'(prod_reg) * (PW+MW)'(RECIP);
        qp   = PW'(qest_reg) * PW'(PULSE_MAX);
        rem  = prod2_reg - qp;
        corr = rem >= PW'(PULSE_MAX);
        if (!(etag_reg.pin_a || etag_reg.pin_b))
        begin
            cmp_next = '0;
        end
        else if (corr)
        begin
            cmp_next = qest_reg;
        end
        else if (qest_reg == '0)
        begin
            cmp_next = '0;
        end
        else
        begin
            cmp_next = qest_reg - CMP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            ve_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            vp_reg <= vp_next;
            ve_reg <= ve_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && p_ready)
        begin
            prod_reg <= {{PERIOD_W{1'b0}}, mag} * {{MAG_W{1'b0}}, period};
            ptag_reg <= tag;
        end
        if (vp_reg && e_ready)
        begin
            qest_reg  <= full[PW +: CMP_W];
            prod2_reg <= prod_reg;
            etag_reg  <= ptag_reg;
        end
        if (ve_reg && o_ready)
        begin
            cmp_reg  <= cmp_next;
            otag_reg <= etag_reg;
        end
    end

    assign out_valid = vo_reg;
    assign cmp       = cmp_reg;
    assign out_tag   = otag_reg;

endmodule

/* hw/rtl/hbridge_speed_to_pwm_core.sv */
// Top level of the H-bridge speed-to-PWM core: dead-zone, direction and output pipeline.
//
// Each word on the input carries a signed speed request and yields exactly one output
// word with the bridge pin levels, the PWM compare value, the new direction and the
// break-before-make flag. The core takes one word per clock cycle while the output is
// not stalled; after its input is accepted, a word passes through the input register,
// the direction stage, the period multiplier, the reciprocal multiplier that divides by
// PULSE_MAX and the correction stage that holds the result. A stalled output fills the
// five stages before the input stalls. Configuration writes are taken in every cycle
// and are meant for an idle core.
module hbridge_speed_to_pwm_core
    import hbsp_pkg::*;
#(
    parameter int PULSE_MAX = PULSE_MAX_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SPEED_W-1:0]    speed_request,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         pin_a,
    output logic                         pin_b,
    output logic [CMP_W-1:0]             compare_value,
    output logic [DIR_W-1:0]             direction,
    output logic                         switching
);

    localparam int MAG_W = $clog2(PULSE_MAX + 1);
    localparam int SUM_W = SPEED_W + 2;

    logic [DZ_W-1:0]            dz_fwd_reg;
    logic [DZ_W-1:0]            dz_bwd_reg;
    logic                       invert_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [DIR_W-1:0]           last_dir_reg, last_dir_next;

    logic                       v1_reg, v1_next;
    logic signed [SPEED_W-1:0]  spd_reg;
    logic                       v2_reg, v2_next;
    logic [MAG_W-1:0]           mag_reg;
    hbsp_tag_t                  tag_reg;
    logic                       s2_ready;
    logic                       scale_ready;
    logic                       adv1;

    logic [SUM_W-1:0]           spd_ext;
    logic [SUM_W-1:0]           sum;
    logic [SUM_W-1:0]           mag_full;
    logic                       is_zero;
    logic                       fwd;
    logic [DIR_W-1:0]           dir;
    logic [MAG_W-1:0]           mag;
    hbsp_tag_t                  tag_next;
    hbsp_tag_t                  out_tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_fwd_reg <= DZ_FWD_RST;
            dz_bwd_reg <= DZ_BWD_RST;
            invert_reg <= 1'b0;
            period_reg <= PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DZ_FWD: dz_fwd_reg <= cfg_data[DZ_W-1:0];
                REG_DZ_BWD: dz_bwd_reg <= cfg_data[DZ_W-1:0];
                REG_INVERT: invert_reg <= cfg_data[0];
                REG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                default:    ;
            endcase
        end
    end

    assign s2_ready = !v2_reg || scale_ready;
    assign in_ready = !v1_reg || s2_ready;
    assign adv1     = v1_reg && s2_ready;
    assign v1_next  = in_ready ? in_valid : v1_reg;
    assign v2_next  = s2_ready ? v1_reg : v2_reg;

    always_comb
    begin
        spd_ext = {{(SUM_W-SPEED_W){spd_reg[SPEED_W-1]}}, spd_reg};
        is_zero = spd_reg == '0;
        if (spd_reg[SPEED_W-1])
        begin
            sum = spd_ext - {{(SUM_W-DZ_W){1'b0}}, dz_bwd_reg};
        end
        else if (!is_zero)
        begin
            sum = spd_ext + {{(SUM_W-DZ_W){1'b0}}, dz_fwd_reg};
        end
        else
        begin
            sum = '0;
        end
        mag_full = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
        fwd      = !sum[SUM_W-1] ^ invert_reg;
        if (is_zero)
        begin
            dir = DIR_STOP;
        end
        else if (fwd)
        begin
            dir = DIR_FWD;
        end
        else
        begin
            dir = DIR_BACK;
        end
        if (mag_full > SUM_W'(PULSE_MAX))
        begin
            mag = MAG_W'(PULSE_MAX);
        end
        else
        begin
            mag = mag_full[MAG_W-1:0];
        end
        tag_next.dir   = dir;
        tag_next.sw    = dir != last_dir_reg;
        tag_next.pin_a = (dir == last_dir_reg) && (dir == DIR_FWD);
        tag_next.pin_b = (dir == last_dir_reg) && (dir == DIR_BACK);
        last_dir_next  = adv1 ? dir : last_dir_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            last_dir_reg <= DIR_FWD;
        end
        else
        begin
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            last_dir_reg <= last_dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            spd_reg <= speed_request;
        end
        if (adv1)
        begin
            mag_reg <= mag;
            tag_reg <= tag_next;
        end
    end

    hbsp_scale #(
        .PULSE_MAX (PULSE_MAX)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_ready  (scale_ready),
        .mag       (mag_reg),
        .tag       (tag_reg),
        .period    (period_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmp       (compare_value),
        .out_tag   (out_tag)
    );

    assign pin_a     = out_tag.pin_a;
    assign pin_b     = out_tag.pin_b;
    assign direction = out_tag.dir;
    assign switching = out_tag.sw;

`ifndef SYNTHESIS
    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pin_a && pin_b))
        else $error("both bridge legs driven");

    a_switch_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && switching) |-> (!pin_a && !pin_b && compare_value == '0))
        else $error("bridge not held off while switching");

    a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && direction == DIR_STOP) |-> (!pin_a && !pin_b && compare_value == '0))
        else $error("bridge driven while stopped");

    a_pin_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!pin_a || direction == DIR_FWD) && (!pin_b || direction == DIR_BACK)))
        else $error("pin level disagrees with direction");
`endif

endmodule
